// ----- sv/uvpl_pkg.sv -----
// ----------------------------------------------------------------------------
// uvpl_pkg
// shared types and codes for the unique value positional list core
// ----------------------------------------------------------------------------
package uvpl_pkg;

    // fixed field widths
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 3;
    localparam int OP_W     = 2;

    // packed word widths on the stream ports
    localparam int S_DATA_W = 40;   // value, position, zero fill
    localparam int M_DATA_W = 40;   // status, found, read_value, zero fill

    // operation codes carried on s_tuser
    typedef enum logic [OP_W-1:0] {
        OP_CONTAINS = 2'd0,
        OP_INSERT   = 2'd1,
        OP_GET      = 2'd2,
        OP_DELETE   = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 3'd0,
        STS_DUP   = 3'd1,
        STS_RANGE = 3'd2,
        STS_EMPTY = 3'd3,
        STS_FULL  = 3'd4
    } status_t;

    // per-cycle command broadcast to every cell
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE
    } cell_cmd_t;

    // control group from the sequencer to the cell row
    typedef struct packed {
        logic                capture;   // latch compare result against probe
        logic [VALUE_W-1:0]  probe;     // value of the incoming word
        cell_cmd_t           cmd;       // shift or hold
        logic [VALUE_W-1:0]  key;       // value written at the insert position
        logic [POS_W-1:0]    pos;       // list position of the current word
    } cell_ctl_t;

endpackage

// ----- sv/uvpl_cell.sv -----
// ----------------------------------------------------------------------------
// uvpl_cell
// one list slot: holds an entry, compares it, shifts with its neighbors
// ----------------------------------------------------------------------------
module uvpl_cell #(
    parameter int INDEX = 0,
    parameter int CMP_W = 7
) (
    input  logic                          aclk,
    input  uvpl_pkg::cell_ctl_t           ctl,
    input  logic [CMP_W-1:0]              length,
    input  logic [uvpl_pkg::VALUE_W-1:0]  left_value,
    input  logic [uvpl_pkg::VALUE_W-1:0]  right_value,
    output logic [uvpl_pkg::VALUE_W-1:0]  entry,
    output logic                          hit,
    output logic [uvpl_pkg::VALUE_W-1:0]  sel_value
);

    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

    logic [uvpl_pkg::VALUE_W-1:0] entry_reg;
    logic [uvpl_pkg::VALUE_W-1:0] entry_next;
    logic                         hit_reg;
    logic [CMP_W-1:0]             pos_ext;
    logic                         in_use;

    assign pos_ext = CMP_W'(ctl.pos);
    assign in_use  = (MY_IDX < length);

    // next entry from the shift command
    always_comb begin
        entry_next = entry_reg;
        unique case (ctl.cmd)
            uvpl_pkg::CELL_HOLD: begin
                entry_next = entry_reg;
            end
            uvpl_pkg::CELL_INSERT: begin
                if (MY_IDX == pos_ext) begin
                    entry_next = ctl.key;
                end else if (MY_IDX > pos_ext) begin
                    entry_next = left_value;
                end
            end
            uvpl_pkg::CELL_DELETE: begin
                if (MY_IDX >= pos_ext) begin
                    entry_next = right_value;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    // entry storage and registered match
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (ctl.capture) begin
            hit_reg <= in_use && (entry_reg == ctl.probe);
        end
    end

    assign entry     = entry_reg;
    assign hit       = hit_reg;
    assign sel_value = (MY_IDX == pos_ext) ? entry_reg : '0;

endmodule

// ----- sv/unique_value_positional_list_core.sv -----
// ----------------------------------------------------------------------------
// unique_value_positional_list_core
// bounded ordered list of unique signed values held in a row of shift cells
// ----------------------------------------------------------------------------
//  channel | dir | word
//  --------+-----+-----------------------------------------------------------
//  s_      | in  | tdata: value[31:0] position[38:32]; tuser: operation[1:0]
//  m_      | out | tdata: status[2:0] found[3] read_value[35:4]
//
//  each word is handled in an accept step, which registers the compare in every
//  cell, and a decide step, which shifts the cell row and loads the result
//  register; the decide step waits while a previous result is still unread
//  reset clears the length and the result valid; entries need no clearing
//  s_tready is high while no word is in the decide step
// ----------------------------------------------------------------------------
module unique_value_positional_list_core #(
    parameter int DEPTH = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [uvpl_pkg::S_DATA_W-1:0]   s_tdata,   // value, position
    input  logic [uvpl_pkg::OP_W-1:0]       s_tuser,   // operation
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [uvpl_pkg::M_DATA_W-1:0]   m_tdata    // status, found, read_value
);

    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (LEN_W > uvpl_pkg::POS_W) ? LEN_W : uvpl_pkg::POS_W;
    localparam int VW    = uvpl_pkg::VALUE_W;
    localparam int PW    = uvpl_pkg::POS_W;

    typedef enum logic {
        S_IDLE,
        S_EVAL
    } state_t;

    state_t                       state_reg;
    uvpl_pkg::op_t                op_reg;
    logic [VW-1:0]                value_reg;
    logic [PW-1:0]                pos_reg;
    logic [LEN_W-1:0]             length_reg;
    logic [LEN_W-1:0]             length_next;
    logic                         m_valid_reg;
    logic [uvpl_pkg::M_DATA_W-1:0] m_data_reg;

    logic                         s_accept;
    logic                         fire;
    uvpl_pkg::cell_ctl_t          ctl;
    uvpl_pkg::cell_cmd_t          cmd_dec;
    uvpl_pkg::status_t            status_dec;
    logic                         found_dec;
    logic [VW-1:0]                rd_dec;
    logic                         any_hit;
    logic [VW-1:0]                sel_or;
    logic [CMP_W-1:0]             len_ext;
    logic [CMP_W-1:0]             pos_ext;

    logic [VW-1:0]                entry_w [DEPTH];
    logic [VW-1:0]                sel_w   [DEPTH];
    logic [DEPTH-1:0]             hit_w;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign fire     = (state_reg == S_EVAL) && (!m_valid_reg || m_tready);
    assign len_ext  = CMP_W'(length_reg);
    assign pos_ext  = CMP_W'(pos_reg);

    // broadcast to the cell row
    always_comb begin
        ctl.capture = s_accept;
        ctl.probe   = s_tdata[VW-1:0];
        ctl.cmd     = fire ? cmd_dec : uvpl_pkg::CELL_HOLD;
        ctl.key     = value_reg;
        ctl.pos     = pos_reg;
    end

    // row of list cells
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [VW-1:0] left_v;
        logic [VW-1:0] right_v;
        if (i == 0) begin : g_first
            assign left_v = value_reg;
        end else begin : g_mid_l
            assign left_v = entry_w[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_v = '0;
        end else begin : g_mid_r
            assign right_v = entry_w[i+1];
        end
        uvpl_cell #(
            .INDEX (i),
            .CMP_W (CMP_W)
        ) u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .length      (len_ext),
            .left_value  (left_v),
            .right_value (right_v),
            .entry       (entry_w[i]),
            .hit         (hit_w[i]),
            .sel_value   (sel_w[i])
        );
    end

    // combine the per-cell match bits and the selected entry
    always_comb begin
        sel_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            sel_or = sel_or | sel_w[i];
        end
    end
    assign any_hit = |hit_w;

    // decide status, shift and new length
    always_comb begin
        cmd_dec     = uvpl_pkg::CELL_HOLD;
        status_dec  = uvpl_pkg::STS_OK;
        found_dec   = 1'b0;
        rd_dec      = '0;
        length_next = length_reg;
        unique case (op_reg)
            uvpl_pkg::OP_CONTAINS: begin
                found_dec = any_hit;
            end
            uvpl_pkg::OP_INSERT: begin
                priority if (any_hit) begin
                    status_dec = uvpl_pkg::STS_DUP;
                end else if (pos_ext > len_ext) begin
                    status_dec = uvpl_pkg::STS_RANGE;
                end else if (length_reg >= LEN_W'(DEPTH)) begin
                    status_dec = uvpl_pkg::STS_FULL;
                end else begin
                    cmd_dec     = uvpl_pkg::CELL_INSERT;
                    length_next = length_reg + LEN_W'(1);
                end
            end
            uvpl_pkg::OP_GET: begin
                priority if (pos_ext > len_ext) begin
                    status_dec = uvpl_pkg::STS_RANGE;
                end else if (length_reg == '0) begin
                    status_dec = uvpl_pkg::STS_EMPTY;
                end else if (pos_ext == len_ext) begin
                    status_dec = uvpl_pkg::STS_RANGE;
                end else begin
                    rd_dec = sel_or;
                end
            end
            uvpl_pkg::OP_DELETE: begin
                priority if (length_reg == '0) begin
                    status_dec = uvpl_pkg::STS_EMPTY;
                end else if (pos_ext >= len_ext) begin
                    status_dec = uvpl_pkg::STS_RANGE;
                end else begin
                    cmd_dec     = uvpl_pkg::CELL_DELETE;
                    length_next = length_reg - LEN_W'(1);
                end
            end
            default: begin
                cmd_dec = uvpl_pkg::CELL_HOLD;
            end
        endcase
    end

    // sequencer state, length and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            length_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && !fire) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        op_reg    <= uvpl_pkg::op_t'(s_tuser);
                        value_reg <= s_tdata[VW-1:0];
                        pos_reg   <= s_tdata[VW+PW-1:VW];
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (fire) begin
                        length_reg  <= length_next;
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {4'b0, rd_dec, found_dec, status_dec};
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- sv/uvpl_checker.sv -----
// ----------------------------------------------------------------------------
// uvpl_checker
// port-level checks for the unique value positional list core
// ----------------------------------------------------------------------------
module uvpl_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [uvpl_pkg::M_DATA_W-1:0] m_tdata
);

    // a stalled result word holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // an accepted word blocks the input while it waits in the decide step
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accept");

    // status is always a defined code
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] == uvpl_pkg::STS_OK) ||
                     (m_tdata[2:0] == uvpl_pkg::STS_DUP) ||
                     (m_tdata[2:0] == uvpl_pkg::STS_RANGE) ||
                     (m_tdata[2:0] == uvpl_pkg::STS_EMPTY) ||
                     (m_tdata[2:0] == uvpl_pkg::STS_FULL))
        else $error("undefined status code");

    // found and read data only go with an ok status
    a_ok_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[3] || (m_tdata[35:4] != '0))
            |-> m_tdata[2:0] == uvpl_pkg::STS_OK)
        else $error("payload with a failing status");

endmodule

bind unique_value_positional_list_core uvpl_checker u_uvpl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- verif/tb_unique_value_positional_list_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_unique_value_positional_list_core
// self-checking bench for the unique value positional list core
// ----------------------------------------------------------------------------
// every accepted word is run through a shadow copy of the list, and the result
// it must give is queued; the result channel is compared field by field with
// the oldest queued result. named tests cover the empty list, extreme values,
// a full store, random operation mixes under three idle settings and a long
// receiver stall that backs the block up into its input
// ----------------------------------------------------------------------------
module tb_unique_value_positional_list_core;

    localparam int DEPTH       = 64;
    localparam int MAX_REPORTS = 10;
    localparam int POOL_SIZE   = 96;
    localparam logic [uvpl_pkg::VALUE_W-1:0] VAL_MIN  = 32'h8000_0000;
    localparam logic [uvpl_pkg::VALUE_W-1:0] VAL_MAX  = 32'h7fff_ffff;
    localparam logic [uvpl_pkg::VALUE_W-1:0] VAL_NEG1 = 32'hffff_ffff;

    // one result word split into its fields
    typedef struct packed {
        uvpl_pkg::status_t            status;
        logic                         found;
        logic [uvpl_pkg::VALUE_W-1:0] read_value;
    } list_result_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [uvpl_pkg::S_DATA_W-1:0]   s_tdata  = '0;   // value[31:0] position[38:32] zero[39]
    logic [uvpl_pkg::OP_W-1:0]       s_tuser  = '0;   // operation[1:0]
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [uvpl_pkg::M_DATA_W-1:0]   m_tdata;         // status[2:0] found[3] read_value[35:4]

    // shadow list and the results still owed by the block
    logic [uvpl_pkg::VALUE_W-1:0]    shadow_list[$];
    list_result_t                    owed_results[$];
    logic [uvpl_pkg::VALUE_W-1:0]    value_pool[POOL_SIZE];

    int mismatches    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_left    = 0;

    always #5 aclk = ~aclk;

    unique_value_positional_list_core #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // membership over the live part of the shadow list
    function automatic bit list_holds(logic [uvpl_pkg::VALUE_W-1:0] v);
        foreach (shadow_list[i]) begin
            if (shadow_list[i] == v) return 1'b1;
        end
        return 1'b0;
    endfunction

    // apply one operation to the shadow list and return the result it gives
    function automatic list_result_t apply_list_op(uvpl_pkg::op_t op,
                                                   logic [uvpl_pkg::VALUE_W-1:0] v,
                                                   logic [uvpl_pkg::POS_W-1:0] pos);
        list_result_t r;
        int len;
        int p;
        r   = '{status: uvpl_pkg::STS_OK, found: 1'b0, read_value: '0};
        len = shadow_list.size();
        p   = int'(pos);
        unique case (op)
            uvpl_pkg::OP_CONTAINS: begin
                r.found = list_holds(v);
            end
            uvpl_pkg::OP_INSERT: begin
                // duplicate check wins over the range check
                if (list_holds(v)) r.status = uvpl_pkg::STS_DUP;
                else if (p > len) r.status = uvpl_pkg::STS_RANGE;
                else if (len >= DEPTH) r.status = uvpl_pkg::STS_FULL;
                else shadow_list.insert(p, v);
            end
            uvpl_pkg::OP_GET: begin
                // position 0 on an empty list reads as empty, others as range
                if (p > len) r.status = uvpl_pkg::STS_RANGE;
                else if (len == 0) r.status = uvpl_pkg::STS_EMPTY;
                else if (p == len) r.status = uvpl_pkg::STS_RANGE;
                else r.read_value = shadow_list[p];
            end
            default: begin
                if (len == 0) r.status = uvpl_pkg::STS_EMPTY;
                else if (p >= len) r.status = uvpl_pkg::STS_RANGE;
                else shadow_list.delete(p);
            end
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(string what, longint unsigned want, longint unsigned got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t mismatch %s: expected %0h got %0h", $realtime, what, want, got);
    endtask

    // offer one word, wait for the accept edge, then predict its result
    task automatic send_word(uvpl_pkg::op_t op, logic [uvpl_pkg::VALUE_W-1:0] v,
                             logic [uvpl_pkg::POS_W-1:0] pos);
        list_result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, pos, v};
        s_tuser  <= op;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        r = apply_list_op(op, v, pos);
        owed_results.push_back(r);
    endtask

    // receiver: random idling, or a counted hold-off when one is requested
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result check, sampled mid-cycle ahead of the accept edge
    always @(negedge aclk) begin
        list_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (owed_results.size() == 0) begin
                flag_mismatch("word with nothing pending", 64'(0), 64'(m_tdata));
            end else begin
                want = owed_results.pop_front();
                if (m_tdata[2:0] != want.status)
                    flag_mismatch("status", 64'(want.status), 64'(m_tdata[2:0]));
                if (m_tdata[3] != want.found)
                    flag_mismatch("found", 64'(want.found), 64'(m_tdata[3]));
                if (m_tdata[35:4] != want.read_value)
                    flag_mismatch("read_value", 64'(want.read_value),
                                  64'(m_tdata[35:4]));
            end
        end
    end

    function automatic void refill_pool();
        foreach (value_pool[i]) value_pool[i] = $urandom();
        value_pool[0] = VAL_MIN;
        value_pool[1] = VAL_MAX;
        value_pool[2] = '0;
    endfunction

    function automatic logic [uvpl_pkg::VALUE_W-1:0] pick_value();
        if ($urandom_range(99) < 85) return value_pool[$urandom_range(POOL_SIZE-1)];
        return $urandom();
    endfunction

    // every operation against an empty list
    task automatic test_empty_list();
        send_word(uvpl_pkg::OP_CONTAINS, '0, 7'd0);
        send_word(uvpl_pkg::OP_GET, VAL_MAX, 7'd0);
        send_word(uvpl_pkg::OP_GET, VAL_MIN, 7'd1);
        send_word(uvpl_pkg::OP_GET, '0, 7'd64);
        send_word(uvpl_pkg::OP_DELETE, VAL_NEG1, 7'd0);
        send_word(uvpl_pkg::OP_DELETE, '0, 7'd64);
        send_word(uvpl_pkg::OP_INSERT, 32'd9, 7'd1);
        send_word(uvpl_pkg::OP_INSERT, 32'd9, 7'd64);
    endtask

    // extreme values, duplicates, positions at and past the length
    task automatic test_edge_values();
        send_word(uvpl_pkg::OP_INSERT, VAL_MIN, 7'd0);
        send_word(uvpl_pkg::OP_INSERT, VAL_MAX, 7'd1);
        send_word(uvpl_pkg::OP_INSERT, VAL_NEG1, 7'd1);
        send_word(uvpl_pkg::OP_INSERT, '0, 7'd0);
        send_word(uvpl_pkg::OP_INSERT, VAL_MAX, 7'd0);
        send_word(uvpl_pkg::OP_INSERT, VAL_NEG1, 7'd64);
        send_word(uvpl_pkg::OP_INSERT, 32'd7, 7'd5);
        send_word(uvpl_pkg::OP_CONTAINS, VAL_MAX, 7'd0);
        send_word(uvpl_pkg::OP_CONTAINS, 32'd1, 7'd0);
        send_word(uvpl_pkg::OP_GET, '0, 7'd3);
        send_word(uvpl_pkg::OP_GET, '0, 7'd4);
        send_word(uvpl_pkg::OP_GET, '0, 7'd64);
        send_word(uvpl_pkg::OP_DELETE, '0, 7'd4);
        send_word(uvpl_pkg::OP_DELETE, '0, 7'd1);
        send_word(uvpl_pkg::OP_DELETE, '0, 7'd2);
        send_word(uvpl_pkg::OP_GET, '0, 7'd0);
        send_word(uvpl_pkg::OP_INSERT, 32'd5, 7'd2);
        send_word(uvpl_pkg::OP_CONTAINS, VAL_MIN, 7'd0);
    endtask

    // fill to capacity at random positions, probe the full store, then drain
    task automatic test_full_store();
        logic [uvpl_pkg::VALUE_W-1:0] held;
        while (shadow_list.size() < DEPTH)
            send_word(uvpl_pkg::OP_INSERT, $urandom(),
                      uvpl_pkg::POS_W'($urandom_range(shadow_list.size())));
        held = shadow_list[$urandom_range(DEPTH-1)];
        send_word(uvpl_pkg::OP_INSERT, $urandom(), 7'd64);
        send_word(uvpl_pkg::OP_INSERT, $urandom(), 7'd0);
        send_word(uvpl_pkg::OP_INSERT, held, 7'd10);
        send_word(uvpl_pkg::OP_CONTAINS, held, 7'd0);
        send_word(uvpl_pkg::OP_GET, $urandom(), 7'd63);
        send_word(uvpl_pkg::OP_GET, $urandom(), 7'd64);
        send_word(uvpl_pkg::OP_DELETE, $urandom(), 7'd64);
        while (shadow_list.size() > 0)
            send_word(uvpl_pkg::OP_DELETE, $urandom(),
                      uvpl_pkg::POS_W'($urandom_range(shadow_list.size()-1)));
    endtask

    // random mix that swings between growing and shrinking the list
    task automatic test_random_mix(int n_words);
        bit                         growing;
        int                         k;
        int                         len;
        int                         roll;
        uvpl_pkg::op_t              op;
        logic [uvpl_pkg::POS_W-1:0] pos;
        growing = 1'b1;
        refill_pool();
        for (k = 0; k < n_words; k++) begin
            len = shadow_list.size();
            if (len >= DEPTH) growing = 1'b0;
            else if (len == 0) growing = 1'b1;
            else if ($urandom_range(99) < 3) growing = !growing;
            roll = $urandom_range(99);
            if (roll < 12) op = uvpl_pkg::OP_CONTAINS;
            else if (roll < 25) op = uvpl_pkg::OP_GET;
            else if (roll < 75) op = growing ? uvpl_pkg::OP_INSERT : uvpl_pkg::OP_DELETE;
            else op = growing ? uvpl_pkg::OP_DELETE : uvpl_pkg::OP_INSERT;
            // mostly legal positions, some anywhere from 0 to the depth
            if ($urandom_range(99) < 85)
                pos = (op == uvpl_pkg::OP_INSERT || len == 0)
                    ? uvpl_pkg::POS_W'($urandom_range(len))
                    : uvpl_pkg::POS_W'($urandom_range(len-1));
            else
                pos = uvpl_pkg::POS_W'($urandom_range(DEPTH));
            send_word(op, pick_value(), pos);
        end
    endtask

    // receiver holds off while the sender keeps offering words back to back
    task automatic test_backpressure();
        int saved_idle;
        saved_idle    = send_idle_pct;
        send_idle_pct = 0;
        s_tvalid <= 1'b0;
        @(negedge aclk);
        stall_left = 300;
        @(posedge aclk);
        test_random_mix(40);
        send_idle_pct = saved_idle;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 33;
        recv_idle_pct = 88;
        test_empty_list();
        test_edge_values();
        test_full_store();
        test_random_mix(600);
        send_idle_pct = 88;
        recv_idle_pct = 33;
        test_random_mix(550);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(550);
        s_tvalid <= 1'b0;
        // drain, then wait for anything stray
        while (owed_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
